/* rtl/core/q4dp_pkg.sv */
// shared types, widths and constants for the q4 block dot product
package q4dp_pkg;

	localparam int BYTES_PER_BLOCK = 16;
	localparam int TOTAL_W = 48;

	localparam int ACT_W = 16;
	localparam int SCALE_W = 16;
	localparam int NIB_W = 4;
	// nibble minus eight times activation
	localparam int LANE_W = NIB_W + ACT_W;
	// two lanes plus growth over the block
	localparam int PARTIAL_W = LANE_W + 1 + $clog2(BYTES_PER_BLOCK);
	localparam int PROD_W = PARTIAL_W + SCALE_W;
	localparam int SUM_W = ((PROD_W > TOTAL_W) ? PROD_W : TOTAL_W) + 1;
	localparam int POS_W = (BYTES_PER_BLOCK > 1) ? $clog2(BYTES_PER_BLOCK) : 1;

	localparam logic [POS_W-1:0] POS_LAST = POS_W'(BYTES_PER_BLOCK - 1);

	localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
	localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

	typedef struct packed {
		logic [7:0]               quant_byte;
		logic signed [ACT_W-1:0]   act_low;
		logic signed [ACT_W-1:0]   act_high;
		logic signed [SCALE_W-1:0] block_scale;
		logic                     vector_end;
	} q4dp_item_t;

	typedef struct packed {
		logic signed [TOTAL_W-1:0] dot_sum;
		logic                     saturated;
	} q4dp_result_t;

	// per stage control: item present, vector end, finished block carried
	typedef struct packed {
		logic valid;
		logic last;
		logic blk;
	} q4dp_ctl_t;

endpackage

/* rtl/core/q4dp_lane.sv */
// one multiply lane: signed nibble times activation, registered
module q4dp_lane
	import q4dp_pkg::*;
(
	input  logic                     clk,
	input  logic                     en,
	input  logic [NIB_W-1:0]         nibble,
	input  logic signed [ACT_W-1:0]  act,
	output logic signed [LANE_W-1:0] prod_s1
);

	logic signed [NIB_W-1:0] weight;

	// nibble minus eight is the nibble with its top bit flipped
	assign weight = {~nibble[NIB_W-1], nibble[NIB_W-2:0]};

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= LANE_W'(weight) * LANE_W'(act);
		end
	end

endmodule

/* rtl/core/q4dp_merge.sv */
// merge stage: adds both lanes into the block sum and closes full blocks
module q4dp_merge
	import q4dp_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  q4dp_ctl_t                   ctl_s1,
	input  logic signed [LANE_W-1:0]    lo_s1,
	input  logic signed [LANE_W-1:0]    hi_s1,
	input  logic signed [SCALE_W-1:0]   scale_s1,
	output q4dp_ctl_t                   ctl_s2,
	output logic signed [PARTIAL_W-1:0] blk_sum_s2,
	output logic signed [SCALE_W-1:0]   scale_s2
);

	logic [POS_W-1:0]            pos_q;
	logic signed [PARTIAL_W-1:0] partial_q;
	logic signed [PARTIAL_W-1:0] partial_next;
	logic                        blk_done;

	assign partial_next = partial_q + PARTIAL_W'(lo_s1) + PARTIAL_W'(hi_s1);
	assign blk_done = (pos_q == POS_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			partial_q <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2.valid <= ctl_s1.valid;
			ctl_s2.last <= ctl_s1.valid & ctl_s1.last;
			ctl_s2.blk <= ctl_s1.valid & blk_done;
			if (ctl_s1.valid) begin
				// a vector end drops any unfinished block
				if (blk_done || ctl_s1.last) begin
					pos_q <= '0;
					partial_q <= '0;
				end else begin
					pos_q <= pos_q + POS_W'(1);
					partial_q <= partial_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			blk_sum_s2 <= partial_next;
			scale_s2 <= scale_s1;
		end
	end

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_LAST)
		else $error("block position beyond block length");

	a_blk_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s2.blk |-> ctl_s2.valid)
		else $error("finished block without an item");
`endif

endmodule

/* rtl/core/q4dp_total.sv */
// scale multiply and saturating running total
module q4dp_total
	import q4dp_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  q4dp_ctl_t                   ctl_s2,
	input  logic signed [PARTIAL_W-1:0] blk_sum_s2,
	input  logic signed [SCALE_W-1:0]   scale_s2,
	output logic                        emit,
	output q4dp_result_t                res_next
);

	q4dp_ctl_t                 ctl_s3;
	logic signed [PROD_W-1:0]  prod_s3;
	logic signed [TOTAL_W-1:0] total_q;
	logic                      flag_q;
	logic signed [SUM_W-1:0]   sum;
	logic signed [TOTAL_W-1:0] total_next;
	logic                      sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= PROD_W'(blk_sum_s2) * PROD_W'(scale_s2);
		end
	end

	always_comb begin
		sum = SUM_W'(total_q) + SUM_W'(prod_s3);
		sat = 1'b0;
		total_next = total_q;
		if (ctl_s3.blk) begin
			if (sum > SUM_W'(TOTAL_MAX)) begin
				total_next = TOTAL_MAX;
				sat = 1'b1;
			end else if (sum < SUM_W'(TOTAL_MIN)) begin
				total_next = TOTAL_MIN;
				sat = 1'b1;
			end else begin
				total_next = TOTAL_W'(sum);
			end
		end
	end

	assign emit = ctl_s3.valid & ctl_s3.last;
	assign res_next.dot_sum = total_next;
	assign res_next.saturated = flag_q | sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			flag_q <= 1'b0;
		end else if (en && ctl_s3.valid) begin
			if (ctl_s3.last) begin
				total_q <= '0;
				flag_q <= 1'b0;
			end else begin
				total_q <= total_next;
				flag_q <= flag_q | sat;
			end
		end
	end

`ifndef SYNTHESIS
	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		en && emit |=> total_q == '0 && !flag_q)
		else $error("total not cleared after vector end");
`endif

endmodule

/* rtl/core/q4_block_dot_product_top.sv */
// top level of the q4 block quantized dot product
//
// streams one packed 4-bit weight byte per request with its two Q8.8
// activations; the low nibble and the high nibble, each minus eight, are
// multiplied in two parallel lanes and merged into a block sum. after
// BYTES_PER_BLOCK bytes the block sum times the Q4.12 block scale is added,
// saturating at 48 bits, into the running total (20 fractional bits). a
// request with vector_end set produces one result (total and sticky
// saturation flag) and clears all state; a block left unfinished at the
// vector end is dropped. block_scale is only read on a block's last byte.
// throughput is one request per clock while the result side keeps up; the
// result of a vector_end request passes lane multiply, merge, scale multiply
// and saturating add into the result register. a held result stalls the
// whole pipeline and item_ready drops with it.
module q4_block_dot_product_top
	import q4dp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_ready,
	input  q4dp_item_t   item,
	output logic         result_valid,
	input  logic         result_ready,
	output q4dp_result_t result
);

	logic                        en;
	q4dp_ctl_t                   ctl_s1;
	q4dp_ctl_t                   ctl_s2;
	logic signed [LANE_W-1:0]    lo_s1;
	logic signed [LANE_W-1:0]    hi_s1;
	logic signed [SCALE_W-1:0]   scale_s1;
	logic signed [PARTIAL_W-1:0] blk_sum_s2;
	logic signed [SCALE_W-1:0]   scale_s2;
	logic                        emit;
	q4dp_result_t                res_next;
	logic                        result_valid_q;
	q4dp_result_t                result_q;

	// whole pipeline moves unless a finished result is still waiting
	assign en = !result_valid_q || result_ready;
	assign item_ready = en;

	// stage 1 control and scale, lanes register their own products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid <= item_valid;
			ctl_s1.last <= item.vector_end;
			ctl_s1.blk <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			scale_s1 <= item.block_scale;
		end
	end

	// low nibble lane: element j
	q4dp_lane u_lane_lo (
		.clk     (clk),
		.en      (en),
		.nibble  (item.quant_byte[NIB_W-1:0]),
		.act     (item.act_low),
		.prod_s1 (lo_s1)
	);

	// high nibble lane: element j+16
	q4dp_lane u_lane_hi (
		.clk     (clk),
		.en      (en),
		.nibble  (item.quant_byte[2*NIB_W-1:NIB_W]),
		.act     (item.act_high),
		.prod_s1 (hi_s1)
	);

	// merge lanes into the block sum
	q4dp_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.ctl_s1     (ctl_s1),
		.lo_s1      (lo_s1),
		.hi_s1      (hi_s1),
		.scale_s1   (scale_s1),
		.ctl_s2     (ctl_s2),
		.blk_sum_s2 (blk_sum_s2),
		.scale_s2   (scale_s2)
	);

	// scale and accumulate into the saturating total
	q4dp_total u_total (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.ctl_s2     (ctl_s2),
		.blk_sum_s2 (blk_sum_s2),
		.scale_s2   (scale_s2),
		.emit       (emit),
		.res_next   (res_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (en) begin
			result_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en && emit) begin
			result_q <= res_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_result_from_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(en && emit))
		else $error("result without a vector end request");
`endif

endmodule

/* test/q4dp_sum_checker.sv */
`timescale 1ns / 100ps
// checker for the q4 block dot product: predicts each vector's total and compares results
module q4dp_sum_checker
	import q4dp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	input  logic         item_ready,
	input  q4dp_item_t   item,
	input  logic         result_valid,
	input  logic         result_ready,
	input  q4dp_result_t result,
	output int           fail_total,
	output int           still_due
);

	int unsigned    bytes_in_block;
	longint         block_sum;
	longint         vector_total;
	logic           clamp_seen;
	int             mismatch_count;
	q4dp_result_t   expected_totals[$];

	task automatic clear_vector();
		bytes_in_block = 0;
		block_sum = 0;
		vector_total = 0;
		clamp_seen = 1'b0;
	endtask

	// one packed byte into the block sum, block close-out, vector end
	task automatic take_byte(input q4dp_item_t req);
		longint       lo_w;
		longint       hi_w;
		longint       scaled;
		longint       next_total;
		q4dp_result_t want;
		lo_w = longint'(req.quant_byte[3:0]) - 8;
		hi_w = longint'(req.quant_byte[7:4]) - 8;
		block_sum += lo_w * longint'(req.act_low) + hi_w * longint'(req.act_high);
		bytes_in_block++;
		if (bytes_in_block >= BYTES_PER_BLOCK) begin
			scaled = block_sum * longint'(req.block_scale);
			next_total = vector_total + scaled;
			if (next_total > longint'(TOTAL_MAX)) begin
				vector_total = longint'(TOTAL_MAX);
				clamp_seen = 1'b1;
			end else if (next_total < longint'(TOTAL_MIN)) begin
				vector_total = longint'(TOTAL_MIN);
				clamp_seen = 1'b1;
			end else begin
				vector_total = next_total;
			end
			block_sum = 0;
			bytes_in_block = 0;
		end
		if (req.vector_end) begin
			want.dot_sum = vector_total[TOTAL_W-1:0];
			want.saturated = clamp_seen;
			expected_totals.push_back(want);
			clear_vector();
		end
	endtask

	task automatic log_mismatch(input string what, input q4dp_result_t want,
			input q4dp_result_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch, %s: expected dot_sum=%0d saturated=%0b, got dot_sum=%0d saturated=%0b",
				what, $signed(want.dot_sum), want.saturated, $signed(got.dot_sum),
				got.saturated);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_vector();
			expected_totals.delete();
			mismatch_count = 0;
			fail_total <= 0;
			still_due <= 0;
		end else begin
			if (item_valid && item_ready)
				take_byte(item);
			if (result_valid && result_ready) begin
				if (expected_totals.size() == 0)
					log_mismatch("result with no request pending", '0, result);
				else if (result !== expected_totals[0])
					log_mismatch("wrong total", expected_totals[0], result);
				if (expected_totals.size() != 0)
					void'(expected_totals.pop_front());
			end
			fail_total <= mismatch_count;
			still_due <= expected_totals.size();
		end
	end

endmodule

/* test/tb_q4_block_dot_product_top.sv */
`timescale 1ns / 100ps
// testbench top for the q4 block dot product: stimulus, stalls and verdict
module tb_q4_block_dot_product_top
	import q4dp_pkg::*;
();

	localparam int RESET_CYCLES = 12;
	localparam int ITEMS_PER_PHASE = 325;
	localparam int CYCLE_LIMIT = 1000000;
	// extra wait after no result is due, as margin
	localparam int DRAIN_CYCLES = 12;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         item_valid;
	logic         item_ready;
	q4dp_item_t   item;
	logic         result_valid;
	logic         result_ready = 1'b0;
	q4dp_result_t result;

	int           fail_total;
	int           still_due;
	int           send_idle_pct;
	int           recv_stall_pct;
	int           cycle_count = 0;

	q4_block_dot_product_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	q4dp_sum_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.fail_total   (fail_total),
		.still_due    (still_due)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// result side stalls at random, the rate set per phase
	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic q4dp_item_t pack_req(input logic [7:0] q, input logic signed [15:0] lo,
			input logic signed [15:0] hi, input logic signed [15:0] sc, input logic last);
		q4dp_item_t req;
		req.quant_byte = q;
		req.act_low = lo;
		req.act_high = hi;
		req.block_scale = sc;
		req.vector_end = last;
		return req;
	endfunction

	// random 16-bit word, leaning on the extremes now and then
	function automatic logic signed [15:0] rand_word();
		case ($urandom_range(7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			3: return 16'shffff;
			default: return 16'($urandom);
		endcase
	endfunction

	// one request: optional idle gap, then hold valid until accepted
	task automatic push_item(input q4dp_item_t req);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= req;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
	endtask

	// vector of random bytes, end mark on the last one
	task automatic send_vector(input int n_bytes);
		for (int k = 0; k < n_bytes; k++)
			push_item(pack_req(8'($urandom), rand_word(), rand_word(), rand_word(),
				k == n_bytes - 1));
	endtask

	// whole blocks most often, some with a dropped tail, some tiny vectors
	function automatic int pick_length();
		int r;
		r = $urandom_range(19);
		if (r < 8)
			return 16 * $urandom_range(1, 3);
		else if (r < 14)
			return 16 * $urandom_range(1, 2) + $urandom_range(1, 15);
		else if (r < 17)
			return $urandom_range(2, 15);
		return 1;
	endfunction

	initial begin
		int sent;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single byte vector: its unfinished block is dropped, total is zero
		push_item(pack_req(8'hff, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b1));
		// end byte completes a block; scale only counts on the sixteenth byte
		for (int k = 0; k < 16; k++)
			push_item(pack_req((k % 2) ? 8'hff : 8'h00,
				(k % 2) ? 16'sh7fff : 16'sh8000, (k % 3) ? 16'sh8000 : 16'sh7fff,
				(k == 15) ? 16'sh8000 : rand_word(), k == 15));
		// zero weights, then nibble extremes, all in a dropped partial block
		push_item(pack_req(8'h88, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0));
		push_item(pack_req(8'h0f, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b0));
		push_item(pack_req(8'hf0, 16'sh7fff, 16'sh8000, 16'sh0000, 1'b1));

		// random phases: no idling, sender idle, receiver stalling, both
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 68;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 68;
				end
				default: begin
					send_idle_pct = 34;
					recv_stall_pct = 34;
				end
			endcase
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				int n;
				n = pick_length();
				send_vector(n);
				sent += n;
			end
		end
		item_valid <= 1'b0;

		// drain: still_due is registered, so look after the next edge
		do
			@(posedge clk);
		while (still_due != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_total == 0 && still_due == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
